### hw/rtl/fixed_capacity_set_table_macros.svh
// assertion macros for the set table checker
// each use expands to a labeled concurrent assertion clocked on clk_i
`ifndef FIXED_CAPACITY_SET_TABLE_MACROS_SVH
`define FIXED_CAPACITY_SET_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FCST_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcst same-cycle check failed");

// next-cycle implication, disabled during reset
`define FCST_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcst next-cycle check failed");

`endif

### hw/rtl/fcst_pkg.sv
package fcst_pkg;

  // fixed field widths of the request and response
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 7;

  // defaults for the top level parameters
  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned ITEM_BITS_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_SHIFT,
    ST_READ,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic shift_step;
    logic get_read;
    logic get_capture;
    logic ok_set;
    logic ins_write;
    logic cnt_dec;
    logic res_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic get_hit;
    logic match;
    logic scan_end;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/fcst_if.sv
interface fcst_req_if;
  logic                          valid;
  logic                          ready;
  logic [fcst_pkg::OP_W-1:0]     op;
  logic [fcst_pkg::VALUE_W-1:0]  value;
  logic [fcst_pkg::INDEX_W-1:0]  index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface fcst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [fcst_pkg::VALUE_W-1:0]  item_value;
  logic [fcst_pkg::COUNT_W-1:0]  count;
  logic                          is_empty;

  modport source (output valid, output ok, output item_value, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input item_value, input count,
                  input is_empty, output ready);
endinterface

### hw/rtl/fcst_ctrl.sv
module fcst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  fcst_pkg::dp_status_t status_i,
  output fcst_pkg::dp_cmd_t    cmd_o
);

  fcst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      fcst_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fcst_pkg::ST_DISPATCH;
        end
      end
      fcst_pkg::ST_DISPATCH: begin
        case (status_i.op)
          fcst_pkg::OP_INSERT: begin
            if (status_i.full) begin
              state_d = fcst_pkg::ST_FINISH;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = fcst_pkg::ST_SEARCH;
            end
          end
          fcst_pkg::OP_GET: begin
            if (status_i.get_hit) begin
              cmd_o.get_read = 1'b1;
              state_d        = fcst_pkg::ST_READ;
            end else begin
              state_d = fcst_pkg::ST_FINISH;
            end
          end
          default: begin
            cmd_o.scan_start = 1'b1;
            state_d          = fcst_pkg::ST_SEARCH;
          end
        endcase
      end
      fcst_pkg::ST_SEARCH: begin
        if (status_i.match) begin
          // present: erase compacts, contains succeeds, insert is refused
          case (status_i.op)
            fcst_pkg::OP_ERASE: begin
              cmd_o.ok_set = 1'b1;
              state_d      = fcst_pkg::ST_SHIFT;
            end
            fcst_pkg::OP_CONTAINS: begin
              cmd_o.ok_set = 1'b1;
              state_d      = fcst_pkg::ST_FINISH;
            end
            default: begin
              state_d = fcst_pkg::ST_FINISH;
            end
          endcase
        end else if (status_i.scan_end) begin
          if (status_i.op == fcst_pkg::OP_INSERT) begin
            cmd_o.ins_write = 1'b1;
            cmd_o.ok_set    = 1'b1;
          end
          state_d = fcst_pkg::ST_FINISH;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      fcst_pkg::ST_SHIFT: begin
        if (status_i.scan_end) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = fcst_pkg::ST_FINISH;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      fcst_pkg::ST_READ: begin
        cmd_o.get_capture = 1'b1;
        cmd_o.ok_set      = 1'b1;
        state_d           = fcst_pkg::ST_FINISH;
      end
      fcst_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = fcst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fcst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/fcst_dp.sv
module fcst_dp #(
  parameter int unsigned CAPACITY  = fcst_pkg::CAPACITY_DEF,
  parameter int unsigned ITEM_BITS = fcst_pkg::ITEM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcst_pkg::dp_cmd_t             cmd_i,
  output fcst_pkg::dp_status_t          status_o,
  input  logic [fcst_pkg::OP_W-1:0]     op_i,
  input  logic [fcst_pkg::VALUE_W-1:0]  value_i,
  input  logic [fcst_pkg::INDEX_W-1:0]  index_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic                          ok_o,
  output logic [fcst_pkg::VALUE_W-1:0]  item_value_o,
  output logic [fcst_pkg::COUNT_W-1:0]  count_o,
  output logic                          is_empty_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W  = (CNT_W > fcst_pkg::INDEX_W) ? CNT_W : fcst_pkg::INDEX_W;

  logic [ITEM_BITS-1:0] entries_q [CAPACITY];

  fcst_pkg::op_e                op_q;
  logic [ITEM_BITS-1:0]         val_q;
  logic [fcst_pkg::INDEX_W-1:0] idx_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [CNT_W-1:0]             ptr_q;
  logic                         pend_q;
  logic [ADDR_W-1:0]            pend_idx_q;
  logic [ITEM_BITS-1:0]         rdata_q;
  logic                         ok_q;
  logic [fcst_pkg::VALUE_W-1:0] get_q;

  logic                          out_valid_q;
  logic                          out_ok_q;
  logic [fcst_pkg::VALUE_W-1:0]  out_item_q;
  logic [fcst_pkg::COUNT_W-1:0]  out_cnt_q;
  logic                          out_empty_q;

  logic                 ptr_lt_cnt;
  logic                 issue;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ITEM_BITS-1:0] wr_data;

  assign ptr_lt_cnt = (ptr_q < cnt_q);
  assign issue      = ((cmd_i.scan_step || cmd_i.shift_step) && ptr_lt_cnt) || cmd_i.get_read;
  assign rd_addr    = cmd_i.get_read ? ADDR_W'(idx_q) : ptr_q[ADDR_W-1:0];

  // compaction writes the entry read last cycle one place lower
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[ADDR_W-1:0];
    wr_data = val_q;
    if (cmd_i.ins_write) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift_step && pend_q) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx_q - ADDR_W'(1);
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= entries_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= fcst_pkg::op_e'(op_i);
      val_q <= ITEM_BITS'(value_i);
      idx_q <= index_i;
    end
    if (issue) begin
      pend_idx_q <= rd_addr;
    end
    if (cmd_i.get_capture) begin
      get_q <= fcst_pkg::VALUE_W'(rdata_q);
    end else if (cmd_i.load) begin
      get_q <= '0;
    end
    if (cmd_i.res_load) begin
      out_ok_q    <= ok_q;
      out_item_q  <= get_q;
      out_cnt_q   <= fcst_pkg::COUNT_W'(cnt_q);
      out_empty_q <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (cmd_i.scan_start) begin
        ptr_q <= '0;
      end else if (issue && !cmd_i.get_read) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      if (cmd_i.load) begin
        ok_q <= 1'b0;
      end else if (cmd_i.ok_set) begin
        ok_q <= 1'b1;
      end
      if (cmd_i.ins_write) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.op       = op_q;
  assign status_o.full     = (cnt_q == CNT_W'(CAPACITY));
  assign status_o.get_hit  = (CMP_W'(idx_q) < CMP_W'(cnt_q));
  assign status_o.match    = pend_q && (rdata_q == val_q);
  assign status_o.scan_end = !pend_q && !ptr_lt_cnt;
  assign status_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign item_value_o = out_item_q;
  assign count_o      = out_cnt_q;
  assign is_empty_o   = out_empty_q;

endmodule

### hw/rtl/fixed_capacity_set_table.sv
// set of up to CAPACITY unique values, kept in insertion order in one memory
// request channel req_i carries op, value and index; response channel rsp_o
// carries ok, item_value, count and is_empty, one response per request
// ops: insert appends an absent value if not full, erase removes a value and
// moves later entries down one place, contains tests membership, get reads
// the entry at index when index is below the count
// one request is worked at a time; req_i.ready is high only while idle
// get, and insert into a full set, skip the scan; contains and insert scan
// the entries linearly, one entry a cycle; erase searches to the hit at
// position p, then compacts the entries after p one place down
// ready returns the cycle after the response is loaded
// the single-port read of the entry memory, one entry per cycle, bounds the scan
// and the compaction
// the response sits in an output register, so a new request is taken while
// the previous response waits; the next response waits if the receiver stalls
// reset clears the count and the control state; entry contents are not cleared
module fixed_capacity_set_table #(
  parameter int unsigned CAPACITY  = fcst_pkg::CAPACITY_DEF,
  parameter int unsigned ITEM_BITS = fcst_pkg::ITEM_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  fcst_req_if.sink   req_i,
  fcst_rsp_if.source rsp_o
);

  // command and status between the sequencer and the datapath
  fcst_pkg::dp_cmd_t    cmd;
  fcst_pkg::dp_status_t status;

  // sequencer: dispatch, scan, compaction and result hand-off
  fcst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // entry memory, count, scan pointer and response register
  fcst_dp #(
    .CAPACITY  (CAPACITY),
    .ITEM_BITS (ITEM_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (req_i.op),
    .value_i      (req_i.value),
    .index_i      (req_i.index),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .ok_o         (rsp_o.ok),
    .item_value_o (rsp_o.item_value),
    .count_o      (rsp_o.count),
    .is_empty_o   (rsp_o.is_empty)
  );

endmodule

### hw/rtl/fcst_checker.sv
`include "fixed_capacity_set_table_macros.svh"

module fcst_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         rsp_ok_i,
  input logic [fcst_pkg::VALUE_W-1:0] rsp_item_value_i,
  input logic [fcst_pkg::COUNT_W-1:0] rsp_count_i,
  input logic                         rsp_is_empty_i
);

  // a response stays offered until taken
  `FCST_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  // one request in flight: ready drops right after a transaction
  `FCST_ASSERT_NEXT(a_one_in_flight, req_valid_i && req_ready_i, !req_ready_i)
  // only a successful get returns nonzero data
  `FCST_ASSERT_NOW(a_data_needs_ok, rsp_valid_i && (rsp_item_value_i != '0), rsp_ok_i)
  // an empty set reports a zero count
  `FCST_ASSERT_NOW(a_empty_count, rsp_valid_i && rsp_is_empty_i, rsp_count_i == '0)

endmodule

bind fixed_capacity_set_table fcst_checker u_fcst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_ok_i         (rsp_o.ok),
  .rsp_item_value_i (rsp_o.item_value),
  .rsp_count_i      (rsp_o.count),
  .rsp_is_empty_i   (rsp_o.is_empty)
);

### test/tb_fixed_capacity_set_table.sv
module tb_fixed_capacity_set_table;
  import fcst_pkg::*;

  // size of the set as built by the default parameters
  localparam int CAPACITY   = CAPACITY_DEF;
  // random transactions after the directed table
  localparam int RAND_ITEMS = 1525;
  // long receiver hold-off, in cycles, so the block backs up and drops req ready
  localparam int HOLD_CYCLES = 400;
  // extra wait after the last response, scaled with the capacity, with margin
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  // pool of recurring values so inserts, erases and lookups hit each other
  localparam int POOL_SIZE = 80;

  // one response as the block reports it
  typedef struct packed {
    logic                ok;
    logic [VALUE_W-1:0]  item_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } set_rsp_t;

  // one row of the directed table; has_rsp marks a hand-written expectation
  typedef struct packed {
    op_e                 op;
    logic [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]  index;
    logic                has_rsp;
    set_rsp_t            rsp;
  } dir_row_t;

  // random op mix, changed every segment
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_e;

  // directed table: empty set, both value extremes, duplicates, absent erase,
  // get at and beyond the count, erase at the head (compaction) and at the tail
  localparam dir_row_t DIR_ROWS [0:24] = '{
    '{OP_GET,      32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, 1'b1}},
    '{OP_CONTAINS, 32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, 1'b1}},
    '{OP_ERASE,    32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, 1'b1}},
    '{OP_INSERT,   32'h0000_0000, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd1, 1'b0}},
    '{OP_INSERT,   32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_INSERT,   32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_CONTAINS, 32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_GET,      32'h0000_0000, 6'd1,  1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd2, 1'b0}},
    '{OP_GET,      32'h0000_0000, 6'd2,  1'b1, '{1'b0, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_GET,      32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b0, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_INSERT,   32'h1234_5678, 6'd0,  1'b0, '0},
    '{OP_INSERT,   32'hA5A5_A5A5, 6'd0,  1'b0, '0},
    '{OP_ERASE,    32'h0000_0000, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd3, 1'b0}},
    '{OP_GET,      32'h0000_0000, 6'd0,  1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd3, 1'b0}},
    '{OP_GET,      32'h0000_0000, 6'd2,  1'b1, '{1'b1, 32'hA5A5_A5A5, 7'd3, 1'b0}},
    '{OP_ERASE,    32'hA5A5_A5A5, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_ERASE,    32'hA5A5_A5A5, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd2, 1'b0}},
    '{OP_CONTAINS, 32'h1234_5678, 6'd0,  1'b0, '0},
    '{OP_ERASE,    32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd1, 1'b0}},
    '{OP_ERASE,    32'h1234_5678, 6'd0,  1'b1, '{1'b1, 32'h0000_0000, 7'd0, 1'b1}},
    '{OP_GET,      32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd0, 1'b1}},
    '{OP_INSERT,   32'h5A5A_5A5A, 6'd0,  1'b0, '0},
    '{OP_GET,      32'h0000_0000, 6'd0,  1'b0, '0},
    '{OP_CONTAINS, 32'h0000_0000, 6'd0,  1'b1, '{1'b0, 32'h0000_0000, 7'd1, 1'b0}},
    '{OP_INSERT,   32'h7FFF_FFFF, 6'd0,  1'b0, '0}
  };

  logic clk;
  logic rst_n;

  fcst_req_if req ();
  fcst_rsp_if rsp ();

  fixed_capacity_set_table DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // shadow copy of the set, updated at each accepted request
  logic [VALUE_W-1:0] set_entries [CAPACITY];
  int                 set_count;
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];

  // responses still owed by the block, oldest first
  set_rsp_t rsp_pending_q [$];
  int       req_accepted;
  int       error_cnt;
  int       burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // apply one request to the shadow set and return the response it yields
  function automatic set_rsp_t apply_set_op(op_e op, logic [VALUE_W-1:0] value,
                                            logic [INDEX_W-1:0] index);
    set_rsp_t r;
    int       hit_pos;
    r = '0;
    hit_pos = -1;
    for (int k = 0; k < set_count; k++) begin
      if (hit_pos < 0 && set_entries[k] == value) hit_pos = k;
    end
    case (op)
      OP_INSERT: begin
        // only an absent value goes in, and only while there is room
        if (set_count < CAPACITY && hit_pos < 0) begin
          set_entries[set_count] = value;
          set_count++;
          r.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        // later entries move down one place, insertion order is kept
        if (hit_pos >= 0) begin
          for (int k = hit_pos; k < set_count - 1; k++) set_entries[k] = set_entries[k + 1];
          set_count--;
          r.ok = 1'b1;
        end
      end
      OP_CONTAINS: begin
        r.ok = (hit_pos >= 0);
      end
      default: begin
        // get: a position at or past the count reads nothing
        if (int'(index) < set_count) begin
          r.item_value = set_entries[index];
          r.ok = 1'b1;
        end
      end
    endcase
    r.count    = set_count[COUNT_W-1:0];
    r.is_empty = (set_count == 0);
    return r;
  endfunction

  // offer one transaction, wait for it to be taken, then record what it owes
  task automatic issue_req(op_e op, logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] index,
                           logic has_rsp, set_rsp_t typed_rsp);
    set_rsp_t pred;
    int       gap;
    // bursts of back-to-back offers separated by random idle stretches
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        req.valid = 1'b0;
      end
    end
    @(negedge clk);
    req.valid = 1'b1;
    req.op    = op;
    req.value = value;
    req.index = index;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pred = apply_set_op(op, value, index);
    rsp_pending_q.push_back(has_rsp ? typed_rsp : pred);
    req_accepted++;
    burst_left--;
  endtask

  // values drawn at least half the time from what is stored or from the shared pool, so hits are common
  function automatic logic [VALUE_W-1:0] pick_value(int fresh_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < fresh_pct) return $urandom;
    if (set_count > 0 && roll < fresh_pct + (100 - fresh_pct) / 2)
      return set_entries[$urandom_range(0, set_count - 1)];
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic op_e pick_op(op_mix_e mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (roll < 60) ? OP_INSERT : (roll < 70) ? OP_ERASE :
                        (roll < 85) ? OP_CONTAINS : OP_GET;
      MIX_DRAIN: return (roll < 15) ? OP_INSERT : (roll < 70) ? OP_ERASE :
                        (roll < 85) ? OP_CONTAINS : OP_GET;
      default:   return op_e'(roll % 4);
    endcase
  endfunction

  function automatic void check_field(string name, logic [VALUE_W-1:0] exp_v,
                                      logic [VALUE_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      error_cnt++;
    end
  endfunction

  // response monitor: every accepted response against the oldest expectation
  always @(posedge clk) begin
    set_rsp_t exp_rsp;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (rsp_pending_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, got ok=%0b value=0x%0h count=%0d",
                 $time, rsp.ok, rsp.item_value, rsp.count);
        error_cnt++;
      end else begin
        exp_rsp = rsp_pending_q.pop_front();
        check_field("ok", VALUE_W'(exp_rsp.ok), VALUE_W'(rsp.ok));
        check_field("item_value", exp_rsp.item_value, rsp.item_value);
        check_field("count", VALUE_W'(exp_rsp.count), VALUE_W'(rsp.count));
        check_field("is_empty", VALUE_W'(exp_rsp.is_empty), VALUE_W'(rsp.is_empty));
      end
    end
  end

  // receiver: stall pattern switches at random, plus one long hold-off
  initial begin
    int  cyc;
    int  stall_mode;
    int  stall_left;
    bit  hold_done;
    cyc = 0;
    stall_mode = 0;
    stall_left = 0;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && req_accepted >= 40) begin
        // block keeps one response parked, the next one waits and req ready falls
        hold_done = 1'b1;
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      cyc++;
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rsp.ready = 1'b1;
        1: rsp.ready = (cyc % 4) != 3;
        2: rsp.ready = 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            rsp.ready = 1'b0;
            stall_left--;
          end else begin
            rsp.ready = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  // stimulus: reset, directed table, then random segments with shifting op mix
  initial begin
    op_mix_e            mix;
    int                 seg_left;
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    req.valid = 1'b0;
    req.op    = OP_INSERT;
    req.value = '0;
    req.index = '0;
    rst_n = 1'b0;
    set_count = 0;
    req_accepted = 0;
    error_cnt = 0;
    burst_left = 0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < 25; r++) begin
      issue_req(DIR_ROWS[r].op, DIR_ROWS[r].value, DIR_ROWS[r].index,
                DIR_ROWS[r].has_rsp, DIR_ROWS[r].rsp);
    end

    // first segment fills the set so insert-when-full shows up early
    mix = MIX_FILL;
    seg_left = 150;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        mix = op_mix_e'($urandom_range(0, 2));
        seg_left = $urandom_range(40, 150);
      end
      seg_left--;
      op = pick_op(mix);
      value = pick_value(mix == MIX_FILL ? 50 : 20);
      // get mostly inside the stored range, sometimes anywhere in the index field
      if ($urandom_range(0, 4) != 0 && set_count > 0)
        index = INDEX_W'($urandom_range(0, set_count - 1));
      else
        index = INDEX_W'($urandom_range(0, 63));
      issue_req(op, value, index, 1'b0, '0);
    end

    @(negedge clk);
    req.valid = 1'b0;
    while (rsp_pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
